/* rtl/core/vs2d_pkg.sv */
// Shared types and constants for the 2-D vorticity stencil.
package vs2d_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int ADDR_W      = $clog2(MAX_WIDTH);
  localparam int SAMPLE_W    = 16;
  localparam int COL_W       = 10;
  localparam int ROW_W       = 16;
  localparam int VORT_W      = 32;
  localparam int GW_W        = 11;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int WEFF_W      = (ADDR_W + 1 > GW_W) ? ADDR_W + 1 : GW_W;
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1,
    CFG_INV_TWO_DX  = 2'd2,
    CFG_INV_TWO_DY  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] u_sample;
    logic signed [SAMPLE_W-1:0] v_sample;
  } in_req_t;

  typedef struct packed {
    logic signed [VORT_W-1:0] vorticity;
    logic [COL_W-1:0]         column;
    logic [ROW_W-1:0]         row;
    logic                     last_of_frame;
  } out_req_t;

  typedef struct packed {
    logic             has_main;
    logic             has_last;
    logic             interior;
    logic             last_col;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } item_ctl_t;

  typedef struct packed {
    logic     vld_a;
    logic     vld_b;
    out_req_t res_a;
    out_req_t res_b;
  } push_t;

endpackage

/* rtl/core/vorticity_stencil_2d.sv */
// Top level of the streaming central-difference z-vorticity stencil.
//
// Input: one (u,v) request per grid point in raster order on in_valid/in_ready.
// Output: vorticity requests on out_valid/out_ready, each tagged with column,
// row and last_of_frame. Inputs of row 0 give no request; every later input
// gives the request for the point one row above; inputs of the last row give a
// second, zero request for their own point. Edge points give zero.
// Configuration: cfg_we writes cfg_wdata into the register cfg_index selects
// (0 grid_width, 1 grid_height, 2 inv_two_dx, 3 inv_two_dy); write only idle.
// Throughput: one input per cycle while one request per input is produced and
// the receiver keeps out_ready high; during the last row, where each input gives
// two requests, the single output port limits it. Line buffers are read at
// accept; v is rewritten in place at accept and u in the cycle after, with a
// bypass for back-to-back same-column hits. An 8-entry result queue decouples
// the sides; in_ready drops when the queue plus requests still in the pipeline
// leaves less than two free slots, so a stalled receiver backs up into in_ready
// with no request lost.
// Reset (synchronous, rst_n low): position returns to column 0, row 0, the
// queue empties and the registers take their defaults. Line buffers keep
// their contents and are not cleared.
module vorticity_stencil_2d (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  vs2d_pkg::in_req_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output vs2d_pkg::out_req_t               out_data,
  input  logic                             cfg_we,
  input  logic [vs2d_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vs2d_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import vs2d_pkg::*;

  logic [GW_W-1:0]       gw_r;
  logic [ROW_W-1:0]      gh_r;
  logic [CFG_DATA_W-1:0] inv_dx_r;
  logic [CFG_DATA_W-1:0] inv_dy_r;
  logic [ADDR_W-1:0]     col_r;
  logic [ADDR_W-1:0]     col_nxt;
  logic [ROW_W-1:0]      row_r;
  logic [ROW_W-1:0]      row_nxt;

  logic                  accept;
  logic                  has_room;
  logic [WEFF_W-1:0]     w_eff;
  logic [ROW_W-1:0]      h_eff;
  logic [WEFF_W-1:0]     col_p1;
  logic [ROW_W:0]        row_p1;
  logic                  last_col;
  logic                  last_row;
  item_ctl_t             ctl;
  logic [1:0]            reserve;
  push_t                 push;

  logic signed [SAMPLE_W-1:0] v_here;
  logic signed [SAMPLE_W-1:0] v_next;
  logic signed [SAMPLE_W-1:0] u_cur;
  logic signed [SAMPLE_W-1:0] u_bp;

  assign in_ready = has_room;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (gw_r == '0) begin
      w_eff = WEFF_W'(1);
    end else if (WEFF_W'(gw_r) > WEFF_W'(MAX_WIDTH)) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(gw_r);
    end
  end

  assign h_eff    = (gh_r == '0) ? ROW_W'(1) : gh_r;
  assign col_p1   = WEFF_W'(col_r) + WEFF_W'(1);
  assign row_p1   = {1'b0, row_r} + (ROW_W+1)'(1);
  assign last_col = (col_p1 >= w_eff);
  assign last_row = (row_p1 >= {1'b0, h_eff});

  always_comb begin
    ctl.has_main = (row_r != '0);
    ctl.has_last = last_row;
    ctl.interior = (col_r != '0) && !last_col && (row_r >= ROW_W'(2)) && (row_r < h_eff);
    ctl.last_col = last_col;
    ctl.col      = COL_W'(col_r);
    ctl.row      = row_r;
  end

  assign reserve = accept ? ({1'b0, ctl.has_main} + {1'b0, ctl.has_last}) : 2'd0;
  assign col_nxt = last_col ? '0 : col_r + ADDR_W'(1);
  assign row_nxt = last_row ? '0 : row_p1[ROW_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      if (last_col) begin
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r     <= GW_W'(1024);
      gh_r     <= ROW_W'(1024);
      inv_dx_r <= CFG_DATA_W'(128);
      inv_dy_r <= CFG_DATA_W'(128);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GRID_WIDTH:  gw_r     <= cfg_wdata[GW_W-1:0];
        CFG_GRID_HEIGHT: gh_r     <= cfg_wdata[ROW_W-1:0];
        CFG_INV_TWO_DX:  inv_dx_r <= cfg_wdata;
        CFG_INV_TWO_DY:  inv_dy_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  vs2d_line_buf u_line_buf (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (accept),
    .addr   (col_r),
    .u_in   (in_data.u_sample),
    .v_in   (in_data.v_sample),
    .v_here (v_here),
    .v_next (v_next),
    .u_cur  (u_cur),
    .u_bp   (u_bp)
  );

  vs2d_calc u_calc (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (accept),
    .in_ctl (ctl),
    .v_here (v_here),
    .v_next (v_next),
    .u_cur  (u_cur),
    .u_bp   (u_bp),
    .inv_dx (inv_dx_r),
    .inv_dy (inv_dy_r),
    .push   (push)
  );

  vs2d_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .reserve   (reserve),
    .has_room  (has_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* rtl/core/vs2d_line_buf.sv */
// Line buffers for u (previous two rows) and v (previous row) with read-modify-write.
module vs2d_line_buf (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               rd_en,
  input  logic [vs2d_pkg::ADDR_W-1:0]        addr,
  input  logic signed [vs2d_pkg::SAMPLE_W-1:0] u_in,
  input  logic signed [vs2d_pkg::SAMPLE_W-1:0] v_in,
  output logic signed [vs2d_pkg::SAMPLE_W-1:0] v_here,
  output logic signed [vs2d_pkg::SAMPLE_W-1:0] v_next,
  output logic signed [vs2d_pkg::SAMPLE_W-1:0] u_cur,
  output logic signed [vs2d_pkg::SAMPLE_W-1:0] u_bp
);
  import vs2d_pkg::*;

  logic [2*SAMPLE_W-1:0] u_mem [MAX_WIDTH];
  logic [SAMPLE_W-1:0]   v_mem [MAX_WIDTH];

  logic [2*SAMPLE_W-1:0] u_q_r;
  logic [SAMPLE_W-1:0]   v_here_r;
  logic [SAMPLE_W-1:0]   v_next_r;
  logic                  s1_vld_r;
  logic [ADDR_W-1:0]     s1_addr_r;
  logic [SAMPLE_W-1:0]   s1_u_r;
  logic                  fwd_r;
  logic [2*SAMPLE_W-1:0] fwd_data_r;

  logic [ADDR_W-1:0]     addr_next;
  logic [2*SAMPLE_W-1:0] u_entry;
  logic [SAMPLE_W-1:0]   u_prev_old;

  assign addr_next  = addr + ADDR_W'(1);
  assign u_entry    = fwd_r ? fwd_data_r : u_q_r;
  assign u_prev_old = u_entry[2*SAMPLE_W-1:SAMPLE_W];

  assign v_here = $signed(v_here_r);
  assign v_next = $signed(v_next_r);
  assign u_cur  = $signed(s1_u_r);
  assign u_bp   = $signed(u_entry[SAMPLE_W-1:0]);

  // v: written in place at accept, old values read on both ports
  always_ff @(posedge clk) begin
    if (rd_en) begin
      v_here_r     <= v_mem[addr];
      v_next_r     <= v_mem[addr_next];
      v_mem[addr]  <= v_in;
    end
  end

  // u: entry is {u_prev, u_before_prev}, written back in the cycle after the read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      u_q_r <= u_mem[addr];
    end
    if (s1_vld_r) begin
      u_mem[s1_addr_r] <= {s1_u_r, u_prev_old};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_addr_r <= addr;
      s1_u_r    <= u_in;
    end
    fwd_data_r <= {s1_u_r, u_prev_old};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      fwd_r    <= 1'b0;
    end else begin
      s1_vld_r <= rd_en;
      fwd_r    <= rd_en && s1_vld_r && (s1_addr_r == addr);
    end
  end

endmodule

/* rtl/core/vs2d_calc.sv */
// Difference, scaling and saturation pipeline producing result requests.
module vs2d_calc (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_vld,
  input  vs2d_pkg::item_ctl_t                  in_ctl,
  input  logic signed [vs2d_pkg::SAMPLE_W-1:0] v_here,
  input  logic signed [vs2d_pkg::SAMPLE_W-1:0] v_next,
  input  logic signed [vs2d_pkg::SAMPLE_W-1:0] u_cur,
  input  logic signed [vs2d_pkg::SAMPLE_W-1:0] u_bp,
  input  logic [vs2d_pkg::CFG_DATA_W-1:0]      inv_dx,
  input  logic [vs2d_pkg::CFG_DATA_W-1:0]      inv_dy,
  output vs2d_pkg::push_t                      push
);
  import vs2d_pkg::*;

  localparam int PROD_W = SAMPLE_W + 1 + CFG_DATA_W + 1;
  localparam int DIFF_W = PROD_W + 1;
  localparam logic signed [VORT_W-1:0] VORT_MAX = {1'b0, {(VORT_W-1){1'b1}}};
  localparam logic signed [VORT_W-1:0] VORT_MIN = {1'b1, {(VORT_W-1){1'b0}}};

  logic                       s1_vld_r;
  item_ctl_t                  s1_ctl_r;
  logic signed [SAMPLE_W-1:0] held_r;
  logic signed [SAMPLE_W-1:0] held_nxt;
  logic                       s2_vld_r;
  item_ctl_t                  s2_ctl_r;
  logic signed [PROD_W-1:0]   pdx_r;
  logic signed [PROD_W-1:0]   pdy_r;

  logic signed [SAMPLE_W:0]   dv;
  logic signed [SAMPLE_W:0]   du;
  logic signed [CFG_DATA_W:0] kdx;
  logic signed [CFG_DATA_W:0] kdy;
  logic signed [PROD_W-1:0]   pdx;
  logic signed [PROD_W-1:0]   pdy;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [VORT_W-1:0]   sat;

  assign dv  = (SAMPLE_W+1)'(v_next) - (SAMPLE_W+1)'(held_r);
  assign du  = (SAMPLE_W+1)'(u_cur) - (SAMPLE_W+1)'(u_bp);
  assign kdx = $signed({1'b0, inv_dx});
  assign kdy = $signed({1'b0, inv_dy});
  assign pdx = dv * kdx;
  assign pdy = du * kdy;

  // v of the previous row one column to the left; zero at row start
  assign held_nxt = s1_ctl_r.last_col ? '0 : v_here;

  assign diff = DIFF_W'(pdx_r) - DIFF_W'(pdy_r);

  always_comb begin
    if (diff > DIFF_W'(VORT_MAX)) begin
      sat = VORT_MAX;
    end else if (diff < DIFF_W'(VORT_MIN)) begin
      sat = VORT_MIN;
    end else begin
      sat = diff[VORT_W-1:0];
    end
  end

  always_comb begin
    push.vld_a                 = s2_vld_r && s2_ctl_r.has_main;
    push.vld_b                 = s2_vld_r && s2_ctl_r.has_last;
    push.res_a.vorticity       = s2_ctl_r.interior ? sat : '0;
    push.res_a.column          = s2_ctl_r.col;
    push.res_a.row             = s2_ctl_r.row - ROW_W'(1);
    push.res_a.last_of_frame   = 1'b0;
    push.res_b.vorticity       = '0;
    push.res_b.column          = s2_ctl_r.col;
    push.res_b.row             = s2_ctl_r.row;
    push.res_b.last_of_frame   = s2_ctl_r.last_col;
  end

  always_ff @(posedge clk) begin
    if (in_vld) begin
      s1_ctl_r <= in_ctl;
    end
    if (s1_vld_r) begin
      s2_ctl_r <= s1_ctl_r;
      pdx_r    <= pdx;
      pdy_r    <= pdy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      held_r   <= '0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      if (s1_vld_r) begin
        held_r <= held_nxt;
      end
    end
  end

endmodule

/* rtl/core/vs2d_out_fifo.sv */
// Result queue taking up to two requests per cycle, with credit tracking for the input side.
module vs2d_out_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  vs2d_pkg::push_t    push,
  input  logic [1:0]         reserve,
  output logic               has_room,
  output logic               out_valid,
  input  logic               out_ready,
  output vs2d_pkg::out_req_t out_data
);
  import vs2d_pkg::*;

  out_req_t              mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r;
  logic [FIFO_CNT_W-1:0] count_nxt;
  logic [FIFO_CNT_W-1:0] credit_r;
  logic [FIFO_CNT_W-1:0] credit_nxt;
  logic [1:0]            npush;
  logic                  pop;
  logic [FIFO_PTR_W-1:0] b_ptr;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign out_data  = mem[rd_ptr_r];
  assign has_room  = (credit_r >= FIFO_CNT_W'(2));

  assign npush      = {1'b0, push.vld_a} + {1'b0, push.vld_b};
  assign b_ptr      = push.vld_a ? wr_ptr_r + FIFO_PTR_W'(1) : wr_ptr_r;
  assign wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(npush);
  assign count_nxt  = count_r + FIFO_CNT_W'(npush) - FIFO_CNT_W'(pop);
  assign credit_nxt = credit_r - FIFO_CNT_W'(reserve) + FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.vld_a) begin
      mem[wr_ptr_r] <= push.res_a;
    end
    if (push.vld_b) begin
      mem[b_ptr] <= push.res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      credit_r <= FIFO_CNT_W'(FIFO_DEPTH);
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
      credit_r <= credit_nxt;
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
    end
  end

endmodule

/* rtl/core/vs2d_checker.sv */
// Port-level checks for the vorticity stencil, bound to the top level.
module vs2d_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input vs2d_pkg::out_req_t out_data
);
  import vs2d_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result request changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result request valid right after reset");

  a_edge_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.vorticity != '0) |-> (out_data.column != '0) && (out_data.row != '0))
    else $error("nonzero vorticity on an edge point");

  a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_of_frame |-> (out_data.vorticity == '0))
    else $error("last request of frame carries nonzero vorticity");

  a_flags_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown(in_ready) && !$isunknown(out_valid))
    else $error("handshake flag unknown");

endmodule

bind vorticity_stencil_2d vs2d_checker u_vs2d_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
